>>> hw/rtl/pfir_pkg.sv
// ----------------------------------------------------------------------------
// pfir_pkg: shared constants and types of the polyphase FIR filter bank
// Field widths, request codes and the structs passed between the store,
// the multiply-accumulate unit and the sequencer.
// ----------------------------------------------------------------------------
package pfir_pkg;

    // Filter geometry
    localparam int TAPS_PER_PHASE = 16;
    localparam int PHASES         = 8;
    localparam int STORE_SIZE     = TAPS_PER_PHASE * PHASES;

    // Field widths, fixed by the port definition
    localparam int KIND_W    = 2;
    localparam int SAMPLE_W  = 16;
    localparam int PHASE_W   = 3;
    localparam int CIDX_W    = 7;
    localparam int COEFF_W   = 16;
    localparam int OUT_W     = 24;
    localparam int FRAC_BITS = 15;

    // Derived widths
    localparam int TAP_W  = $clog2(TAPS_PER_PHASE);
    localparam int CF_AW  = (STORE_SIZE > 1) ? $clog2(STORE_SIZE) : 1;
    localparam int PROD_W = SAMPLE_W + COEFF_W;
    localparam int ACC_MIN_W = PROD_W + TAP_W;
    localparam int ACC_SAT_W = FRAC_BITS + OUT_W + 1;
    localparam int ACC_W  = (ACC_MIN_W > ACC_SAT_W) ? ACC_MIN_W : ACC_SAT_W;
    localparam int Q_W    = ACC_W - FRAC_BITS;

    // Request kinds
    localparam logic [KIND_W-1:0] KIND_LOAD = 2'd0;
    localparam logic [KIND_W-1:0] KIND_PUSH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ = 2'd2;

    // Write port of both stores
    typedef struct packed {
        logic                  dl_we;
        logic [TAP_W-1:0]      dl_addr;
        logic [SAMPLE_W-1:0]   dl_data;
        logic                  cf_we;
        logic [CF_AW-1:0]      cf_addr;
        logic [COEFF_W-1:0]    cf_data;
    } wr_req_t;

    // Read port of both stores, one tap per cycle
    typedef struct packed {
        logic                  en;
        logic                  last;
        logic [TAP_W-1:0]      dl_addr;
        logic [CF_AW-1:0]      cf_addr;
    } rd_req_t;

    // Registered read data of one tap
    typedef struct packed {
        logic                  valid;
        logic                  last;
        logic [SAMPLE_W-1:0]   sample;
        logic [COEFF_W-1:0]    coeff;
    } tap_t;

    // Finished dot product
    typedef struct packed {
        logic                  valid;
        logic [OUT_W-1:0]      filtered;
        logic                  saturated;
    } mac_res_t;

endpackage

>>> hw/rtl/pfir_mem.sv
// ----------------------------------------------------------------------------
// pfir_mem: delay line and coefficient store
// Two synchronous memories with registered read data. The delay line keeps
// one valid bit per entry so that entries not yet pushed read as zero.
// ----------------------------------------------------------------------------
module pfir_mem (
    input  logic              aclk,
    input  logic              aresetn,
    input  pfir_pkg::wr_req_t wr_i,
    input  pfir_pkg::rd_req_t rd_i,
    output pfir_pkg::tap_t    tap_o
);
    import pfir_pkg::*;

    logic [SAMPLE_W-1:0]       dl_mem [TAPS_PER_PHASE];
    logic [COEFF_W-1:0]        cf_mem [STORE_SIZE];
    logic [TAPS_PER_PHASE-1:0] dl_vld_reg;

    logic [SAMPLE_W-1:0] dl_rd_reg;
    logic [COEFF_W-1:0]  cf_rd_reg;
    logic                dl_hit_reg;
    logic                tap_valid_reg;
    logic                tap_last_reg;

    // Delay line memory: write port and registered read
    always_ff @(posedge aclk) begin
        if (wr_i.dl_we) begin
            dl_mem[wr_i.dl_addr] <= wr_i.dl_data;
        end
        dl_rd_reg <= dl_mem[rd_i.dl_addr];
    end

    // Coefficient memory: write port and registered read
    always_ff @(posedge aclk) begin
        if (wr_i.cf_we) begin
            cf_mem[wr_i.cf_addr] <= wr_i.cf_data;
        end
        cf_rd_reg <= cf_mem[rd_i.cf_addr];
    end

    // Valid bits of the delay line, read beside the data
    always_ff @(posedge aclk) begin
        dl_hit_reg <= dl_vld_reg[rd_i.dl_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dl_vld_reg    <= '0;
            tap_valid_reg <= 1'b0;
            tap_last_reg  <= 1'b0;
        end else begin
            if (wr_i.dl_we) begin
                dl_vld_reg[wr_i.dl_addr] <= 1'b1;
            end
            tap_valid_reg <= rd_i.en;
            tap_last_reg  <= rd_i.en && rd_i.last;
        end
    end

    // Unpushed slots read as zero
    assign tap_o.valid  = tap_valid_reg;
    assign tap_o.last   = tap_last_reg;
    assign tap_o.sample = dl_hit_reg ? dl_rd_reg : '0;
    assign tap_o.coeff  = cf_rd_reg;

`ifndef SYNTH
    a_tap_follows_read: assert property (@(posedge aclk) disable iff (!aresetn)
        tap_o.valid |-> $past(rd_i.en))
        else $error("tap data without a read one cycle earlier");
`endif

endmodule

>>> hw/rtl/pfir_mac.sv
// ----------------------------------------------------------------------------
// pfir_mac: shared multiply-accumulate unit
// Multiplies one tap per cycle, accumulates exactly, then floors the sum by
// the fraction bits and saturates it to the output width.
// ----------------------------------------------------------------------------
module pfir_mac (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start_i,
    input  pfir_pkg::tap_t     tap_i,
    input  logic               take_i,
    output pfir_pkg::mac_res_t res_o
);
    import pfir_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic                     pvalid_reg;
    logic                     plast_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic                     done_reg;

    logic [Q_W-1:0]   q;
    logic             over;
    logic             under;
    localparam logic [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    // Product stage
    always_ff @(posedge aclk) begin
        prod_reg <= $signed(tap_i.sample) * $signed(tap_i.coeff);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pvalid_reg <= 1'b0;
            plast_reg  <= 1'b0;
        end else begin
            pvalid_reg <= tap_i.valid;
            plast_reg  <= tap_i.valid && tap_i.last;
        end
    end

    // Accumulate stage, cleared when a read request starts
    always_ff @(posedge aclk) begin
        if (start_i) begin
            acc_reg <= '0;
        end else if (pvalid_reg) begin
            acc_reg <= acc_reg + {{(ACC_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
        end
    end

    // Result pending until the sequencer takes it
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else if (start_i) begin
            done_reg <= 1'b0;
        end else if (pvalid_reg && plast_reg) begin
            done_reg <= 1'b1;
        end else if (take_i) begin
            done_reg <= 1'b0;
        end
    end

    // Floor by the fraction bits, then clip to the output range
    assign q     = acc_reg[ACC_W-1:FRAC_BITS];
    assign over  = !q[Q_W-1] && (|q[Q_W-2:OUT_W-1]);
    assign under = q[Q_W-1] && !(&q[Q_W-2:OUT_W-1]);

    assign res_o.valid     = done_reg;
    assign res_o.filtered  = over ? OUT_MAX : (under ? OUT_MIN : q[OUT_W-1:0]);
    assign res_o.saturated = over || under;

`ifndef SYNTH
    a_done_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(done_reg) |-> $past(pvalid_reg && plast_reg))
        else $error("result marked done without its last tap");
`endif

endmodule

>>> hw/rtl/polyphase_fir_filter.sv
// Requests: load and push requests are written into the stores on acceptance;
//   s_ready stays low from a read's acceptance until its result is taken, so
//   no new request is accepted meanwhile; the single multiply-accumulate walks
//   one tap per cycle through the memory port.
// Reset: synchronous, active low; delay line reads as zero, pointer zero.
// ----------------------------------------------------------------------------
// polyphase_fir_filter: polyphase FIR filter bank
// Sequencer that writes coefficients and samples into the stores and walks
// one phase branch, oldest sample first, through the shared MAC.
// ----------------------------------------------------------------------------
module polyphase_fir_filter (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_valid,
    output logic                                  s_ready,
    input  logic [pfir_pkg::KIND_W-1:0]           s_kind,
    input  logic signed [pfir_pkg::SAMPLE_W-1:0]  s_sample,
    input  logic [pfir_pkg::PHASE_W-1:0]          s_phase,
    input  logic [pfir_pkg::CIDX_W-1:0]           s_coeff_index,
    input  logic signed [pfir_pkg::COEFF_W-1:0]   s_coeff_value,
    output logic                                  m_valid,
    input  logic                                  m_ready,
    output logic signed [pfir_pkg::OUT_W-1:0]     m_filtered,
    output logic                                  m_saturated
);
    import pfir_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [TAP_W-1:0] TAP_LAST = TAP_W'(TAPS_PER_PHASE - 1);

    logic [1:0]       state_reg, state_next;
    logic [TAP_W-1:0] wp_reg, wp_next;
    logic [TAP_W-1:0] k_reg, k_next;
    logic [TAP_W-1:0] pos_reg, pos_next;
    logic [CF_AW-1:0] caddr_reg, caddr_next;
    logic             m_valid_reg, m_valid_next;
    logic [OUT_W-1:0] filt_reg;
    logic             sat_reg;

    logic     accept;
    logic     do_push;
    logic     do_load;
    logic     do_read;
    logic     out_free;
    logic     take;
    wr_req_t  wr;
    rd_req_t  rd;
    tap_t     tap;
    mac_res_t res;

    // Request decode
    assign s_ready  = (state_reg == ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign do_push  = accept && (s_kind == KIND_PUSH);
    assign do_load  = accept && (s_kind == KIND_LOAD) && (int'(s_coeff_index) < STORE_SIZE);
    assign do_read  = accept && (s_kind == KIND_READ) && (int'(s_phase) < PHASES);
    assign out_free = !m_valid_reg || m_ready;
    assign take     = (state_reg == ST_WAIT) && res.valid && out_free;

    // Store write port
    assign wr.dl_we   = do_push;
    assign wr.dl_addr = wp_reg;
    assign wr.dl_data = s_sample;
    assign wr.cf_we   = do_load;
    assign wr.cf_addr = CF_AW'(s_coeff_index);
    assign wr.cf_data = s_coeff_value;

    // Store read port, one tap per cycle while running
    assign rd.en      = (state_reg == ST_RUN);
    assign rd.last    = (k_reg == TAP_LAST);
    assign rd.dl_addr = pos_reg;
    assign rd.cf_addr = caddr_reg;

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        wp_next      = wp_reg;
        k_next       = k_reg;
        pos_next     = pos_reg;
        caddr_next   = caddr_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (do_push) begin
            wp_next = (wp_reg == TAP_LAST) ? '0 : wp_reg + 1'b1;
        end
        unique case (state_reg)
            ST_IDLE: begin
                if (do_read) begin
                    state_next = ST_RUN;
                    k_next     = '0;
                    pos_next   = wp_reg;
                    caddr_next = CF_AW'((PHASES - 1 - int'(s_phase)) * TAPS_PER_PHASE);
                end
            end
            ST_RUN: begin
                k_next     = k_reg + 1'b1;
                pos_next   = (pos_reg == TAP_LAST) ? '0 : pos_reg + 1'b1;
                caddr_next = caddr_reg + 1'b1;
                if (k_reg == TAP_LAST) begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT: begin
                if (take) begin
                    state_next   = ST_IDLE;
                    m_valid_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wp_reg      <= '0;
            k_reg       <= '0;
            pos_reg     <= '0;
            caddr_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            k_reg       <= k_next;
            pos_reg     <= pos_next;
            caddr_reg   <= caddr_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (take) begin
            filt_reg <= res.filtered;
            sat_reg  <= res.saturated;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_filtered  = filt_reg;
    assign m_saturated = sat_reg;

    pfir_mem u_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_i    (wr),
        .rd_i    (rd),
        .tap_o   (tap)
    );

    pfir_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start_i (do_read),
        .tap_i   (tap),
        .take_i  (take),
        .res_o   (res)
    );

`ifndef SYNTH
    a_result_from_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_WAIT))
        else $error("result presented outside the wait state");
    a_pointer_held_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |=> $stable(wp_reg))
        else $error("write pointer moved during a read");
`endif

endmodule
